// ----- rtl/dss_pkg.sv -----
package dss_pkg;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DIV_INIT,
    ST_DIVIDE,
    ST_MED_HI,
    ST_MED_LO,
    ST_MED_CALC,
    ST_EMIT,
    ST_FLUSH
  } ctl_state_t;

  // datapath operation for the current cycle
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_INSERT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MED_HI,
    OP_MED_LO,
    OP_MED_CALC,
    OP_EMIT,
    OP_FLUSH
  } dp_op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic full;       // store holds MAX_SAMPLES words
    logic ins_done;   // insertion slot found this cycle
    logic div_last;   // final divider step
    logic emit_last;  // emission index at last rank
  } dp_stat_t;

endpackage

// ----- rtl/dataset_sort_and_statistics.sv -----
// Channel  Handshake          Word
// -------  -----------------  ------------------------------------------------
// input    start / busy       in_sample_value, in_last_sample
// result   out_strobe         out_sorted_value, out_rank, out_end_of_run,
//                             out_mean_floor, out_median_floor, out_largest,
//                             out_smallest, out_set_size, out_overflowed
//
// A word is taken when start is high and busy is low. To keep a sample,
// insertion walks the store one entry per cycle past the kept samples smaller
// than it, through its single read and write port.
// A sample that arrives while the set is full is dropped.
// After the last word: divider init, the divider steps, the median states
// (MED_HI, MED_LO, MED_CALC), then one result per cycle, one per kept sample, and a flush.
// Reset is synchronous, active low; the store needs no clearing pass.
// Results cannot be stalled: each stands for exactly one cycle.
module dataset_sort_and_statistics
  import dss_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_sample_value,
  input  logic       in_last_sample,
  output logic       out_strobe,
  output logic [7:0] out_sorted_value,
  output logic [5:0] out_rank,
  output logic       out_end_of_run,
  output logic [7:0] out_mean_floor,
  output logic [7:0] out_median_floor,
  output logic [7:0] out_largest,
  output logic [7:0] out_smallest,
  output logic [6:0] out_set_size,
  output logic       out_overflowed
);

  // controller issues one datapath operation per cycle
  dp_op_t   op;
  dp_stat_t stat;

  dss_ctl u_ctl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_last_sample (in_last_sample),
    .stat           (stat),
    .op             (op),
    .busy           (busy)
  );

  // store, running stats, divider, median and emission counters
  dss_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_sample_value  (in_sample_value),
    .stat             (stat),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_rank         (out_rank),
    .out_end_of_run   (out_end_of_run),
    .out_mean_floor   (out_mean_floor),
    .out_median_floor (out_median_floor),
    .out_largest      (out_largest),
    .out_smallest     (out_smallest),
    .out_set_size     (out_set_size),
    .out_overflowed   (out_overflowed)
  );

`ifndef SYNTHESIS
  // results only appear while a set is being emitted
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result word outside busy window");

  // emission is one unbroken burst
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_end_of_run |=> out_strobe)
    else $error("gap in result burst");

  // ranks count up by one
  a_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_end_of_run |=> out_rank == $past(out_rank) + 6'd1)
    else $error("rank did not advance");

  // store is read out in descending order
  a_desc: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_end_of_run |=> out_sorted_value <= $past(out_sorted_value))
    else $error("sorted values not descending");

  // burst ends cleanly
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_end_of_run |=> !out_strobe)
    else $error("result after end of run");
`endif

endmodule

// ----- rtl/dss_ctl.sv -----
module dss_ctl
  import dss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last_sample,
  input  dp_stat_t stat,
  output dp_op_t   op,
  output logic     busy
);

  ctl_state_t state_r, state_nxt;
  logic       last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    op        = OP_IDLE;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op       = OP_LOAD;
          last_nxt = in_last_sample;
          if (!stat.full) begin
            state_nxt = ST_INSERT;
          end else if (in_last_sample) begin
            state_nxt = ST_DIV_INIT;
          end
        end
      end
      ST_INSERT: begin
        op = OP_INSERT;
        if (stat.ins_done) begin
          state_nxt = last_r ? ST_DIV_INIT : ST_IDLE;
        end
      end
      ST_DIV_INIT: begin
        op        = OP_DIV_INIT;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        op = OP_DIV_STEP;
        if (stat.div_last) begin
          state_nxt = ST_MED_HI;
        end
      end
      ST_MED_HI: begin
        op        = OP_MED_HI;
        state_nxt = ST_MED_LO;
      end
      ST_MED_LO: begin
        op        = OP_MED_LO;
        state_nxt = ST_MED_CALC;
      end
      ST_MED_CALC: begin
        op        = OP_MED_CALC;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        op = OP_EMIT;
        if (stat.emit_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        op        = OP_FLUSH;
        last_nxt  = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/dss_dp.sv -----
module dss_dp
  import dss_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_op_t     op,
  input  logic [7:0] in_sample_value,
  output dp_stat_t   stat,
  output logic       out_strobe,
  output logic [7:0] out_sorted_value,
  output logic [5:0] out_rank,
  output logic       out_end_of_run,
  output logic [7:0] out_mean_floor,
  output logic [7:0] out_median_floor,
  output logic [7:0] out_largest,
  output logic [7:0] out_smallest,
  output logic [6:0] out_set_size,
  output logic       out_overflowed
);

  localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = 8 + AW;
  localparam int DCW = $clog2(SW + 1);

  // sample store, kept in descending order by insertion
  logic [7:0] mem [MAX_SAMPLES];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata_r;

  // set statistics
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [7:0]    max_r, max_nxt, min_r, min_nxt;
  logic          ovf_r, ovf_nxt;

  // insertion
  logic [7:0]    key_r, key_nxt;
  logic [CW-1:0] j_r, j_nxt;

  // restoring divider
  logic [CW-1:0]  rem_r, rem_nxt;
  logic [SW-1:0]  quo_r, quo_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [CW:0]    rem_sh, rem_diff;

  // median and emission
  logic [7:0]    mid_hi_r, mid_hi_nxt, med_r, med_nxt;
  logic [8:0]    mid_sum;
  logic [CW-1:0] k_r, k_nxt, ek_r, ek_nxt;
  logic          ev_r, ev_nxt;

  logic [CW-1:0] cnt_m1, j_m1, j_m2, half, half_m1;
  logic [CW+6:0] rank_ext, size_ext;
  logic          full, shift_on;

  assign full     = (count_r == CW'(MAX_SAMPLES));
  assign cnt_m1   = count_r - CW'(1);
  assign j_m1     = j_r - CW'(1);
  assign j_m2     = j_r - CW'(2);
  assign half     = count_r >> 1;
  assign half_m1  = half - CW'(1);
  assign shift_on = (j_r != '0) && (rdata_r < key_r);
  assign rem_sh   = {rem_r, quo_r[SW-1]};
  assign rem_diff = rem_sh - {1'b0, count_r};
  assign mid_sum  = {1'b0, mid_hi_r} + {1'b0, rdata_r};

  assign stat.full      = full;
  assign stat.ins_done  = !shift_on;
  assign stat.div_last  = (dcnt_r == DCW'(1));
  assign stat.emit_last = (k_r == cnt_m1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      max_r   <= 8'd0;
      min_r   <= 8'hFF;
      ovf_r   <= 1'b0;
      ev_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      ovf_r   <= ovf_nxt;
      ev_r    <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    j_r      <= j_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dcnt_r   <= dcnt_nxt;
    mid_hi_r <= mid_hi_nxt;
    med_r    <= med_nxt;
    k_r      <= k_nxt;
    ek_r     <= ek_nxt;
  end

  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    max_nxt    = max_r;
    min_nxt    = min_r;
    ovf_nxt    = ovf_r;
    key_nxt    = key_r;
    j_nxt      = j_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    mid_hi_nxt = mid_hi_r;
    med_nxt    = med_r;
    k_nxt      = k_r;
    ek_nxt     = ek_r;
    ev_nxt     = 1'b0;
    we         = 1'b0;
    waddr      = j_r[AW-1:0];
    wdata      = key_r;
    raddr      = k_r[AW-1:0];
    case (op)
      OP_LOAD: begin
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          count_nxt = count_r + CW'(1);
          sum_nxt   = sum_r + SW'(in_sample_value);
          if (in_sample_value > max_r) max_nxt = in_sample_value;
          if (in_sample_value < min_r) min_nxt = in_sample_value;
          key_nxt = in_sample_value;
          j_nxt   = count_r;
          raddr   = cnt_m1[AW-1:0];
        end
      end
      OP_INSERT: begin
        we = 1'b1;
        if (shift_on) begin
          wdata = rdata_r;
          j_nxt = j_m1;
          raddr = j_m2[AW-1:0];
        end
      end
      OP_DIV_INIT: begin
        rem_nxt  = '0;
        quo_nxt  = sum_r;
        dcnt_nxt = DCW'(SW);
      end
      OP_DIV_STEP: begin
        dcnt_nxt = dcnt_r - DCW'(1);
        if (!rem_diff[CW]) begin
          rem_nxt = rem_diff[CW-1:0];
          quo_nxt = {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CW-1:0];
          quo_nxt = {quo_r[SW-2:0], 1'b0};
        end
      end
      OP_MED_HI: begin
        raddr = half[AW-1:0];
      end
      OP_MED_LO: begin
        mid_hi_nxt = rdata_r;
        raddr      = half_m1[AW-1:0];
      end
      OP_MED_CALC: begin
        med_nxt = count_r[0] ? mid_hi_r : mid_sum[8:1];
        k_nxt   = '0;
      end
      OP_EMIT: begin
        raddr  = k_r[AW-1:0];
        k_nxt  = k_r + CW'(1);
        ek_nxt = k_r;
        ev_nxt = 1'b1;
      end
      OP_FLUSH: begin
        count_nxt = '0;
        sum_nxt   = '0;
        max_nxt   = 8'd0;
        min_nxt   = 8'hFF;
        ovf_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign rank_ext = {7'd0, ek_r};
  assign size_ext = {7'd0, count_r};

  assign out_strobe       = ev_r;
  assign out_sorted_value = rdata_r;
  assign out_rank         = rank_ext[5:0];
  assign out_end_of_run   = (ek_r == cnt_m1);
  assign out_mean_floor   = quo_r[7:0];
  assign out_median_floor = med_r;
  assign out_largest      = max_r;
  assign out_smallest     = min_r;
  assign out_set_size     = size_ext[6:0];
  assign out_overflowed   = ovf_r;

endmodule

// ----- tb/sv/dataset_sort_and_statistics_tb.sv -----
module dataset_sort_and_statistics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SAMPLES  = 64;
  localparam int RANDOM_WORDS = 136;
  // No word moves in either direction for this long: the block is hung.
  // Worst natural gap is a full insertion walk or the divide/median
  // run before the first result, plus sender gaps.
  localparam int QUIET_LIMIT  = 1000;
  // Tail after the last result: the flush, with margin.
  localparam int TAIL_CYCLES  = 24;
  localparam int IDLE_PCT     = 38;

  // One result word, one member per result port.
  typedef struct packed {
    logic [7:0] sorted_value;
    logic [5:0] rank;
    logic       end_of_run;
    logic [7:0] mean_floor;
    logic [7:0] median_floor;
    logic [7:0] largest;
    logic [7:0] smallest;
    logic [6:0] set_size;
    logic       overflowed;
  } stat_word_t;

  // Directed table row. Rows with a typed expectation close a one-sample set,
  // so the whole result word can be written down by hand.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       typed;
    stat_word_t want;
  } sample_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] in_sample_value = '0;
  logic       in_last_sample = 1'b0;
  logic       out_strobe;
  logic [7:0] out_sorted_value;
  logic [5:0] out_rank;
  logic       out_end_of_run;
  logic [7:0] out_mean_floor;
  logic [7:0] out_median_floor;
  logic [7:0] out_largest;
  logic [7:0] out_smallest;
  logic [6:0] out_set_size;
  logic       out_overflowed;

  dataset_sort_and_statistics #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_value (in_sample_value),
    .in_last_sample  (in_last_sample),
    .out_strobe      (out_strobe),
    .out_sorted_value(out_sorted_value),
    .out_rank        (out_rank),
    .out_end_of_run  (out_end_of_run),
    .out_mean_floor  (out_mean_floor),
    .out_median_floor(out_median_floor),
    .out_largest     (out_largest),
    .out_smallest    (out_smallest),
    .out_set_size    (out_set_size),
    .out_overflowed  (out_overflowed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block's set state
  // ---------------------------------------------------------------------------
  logic [7:0]  set_store [MAX_SAMPLES];
  int unsigned set_count = 0;
  int unsigned set_sum   = 0;
  logic [7:0]  set_max   = 8'h00;
  logic [7:0]  set_min   = 8'hFF;
  logic        set_ovf   = 1'b0;

  stat_word_t  fresh_words   [$];  // words caused by the sample just taken
  stat_word_t  pending_words [$];  // words still owed by the block, oldest first

  int error_count   = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int sets_closed   = 0;
  int overflow_sets = 0;
  int quiet_cycles  = 0;
  bit idle_enabled  = 1'b1;

  // Folds one accepted sample into the shadow state. On the last mark, sorts
  // the set high to low and fills fresh_words with one word per kept sample.
  function automatic void fold_sample(input logic [7:0] value, input logic last);
    logic [7:0]  ranked [MAX_SAMPLES];
    logic [7:0]  key;
    logic [7:0]  mean_v;
    logic [7:0]  median_v;
    int unsigned n;
    int          j;
    stat_word_t  w;
    fresh_words.delete();
    if (set_count < MAX_SAMPLES) begin
      set_store[set_count] = value;
      set_count++;
      set_sum += value;
      if (value > set_max) set_max = value;
      if (value < set_min) set_min = value;
    end else begin
      set_ovf = 1'b1;  // full: word dropped, flag sticks until emission
    end
    if (!last) return;

    n = set_count;
    for (int i = 0; i < n; i++) ranked[i] = set_store[i];
    // insertion sort, descending; ties keep arrival order (same values anyway)
    for (int i = 1; i < n; i++) begin
      key = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] < key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end

    mean_v = 8'(set_sum / n);
    if (n % 2 == 1) begin
      median_v = ranked[n/2];
    end else begin
      median_v = 8'((int'(ranked[n/2-1]) + int'(ranked[n/2])) / 2);
    end

    for (int k = 0; k < n; k++) begin
      w.sorted_value = ranked[k];
      w.rank         = 6'(k);
      w.end_of_run   = (k == n - 1);
      w.mean_floor   = mean_v;
      w.median_floor = median_v;
      w.largest      = set_max;
      w.smallest     = set_min;
      w.set_size     = 7'(n);
      w.overflowed   = set_ovf;
      fresh_words.push_back(w);
    end

    if (set_ovf) overflow_sets++;
    sets_closed++;
    set_count = 0;
    set_sum   = 0;
    set_max   = 8'h00;
    set_min   = 8'hFF;
    set_ovf   = 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random gaps, then hold start until the block takes the word.
  // start stays high between back-to-back words (no drop-and-raise).
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] value, input logic last,
                           input logic typed, input stat_word_t want);
    while (idle_enabled && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_sample_value <= value;
    in_last_sample  <= last;
    // busy sampled at the edge is its pre-edge value: low means taken
    do @(posedge clk); while (busy !== 1'b0);
    fold_sample(value, last);
    if (typed) begin
      pending_words.push_back(want);
    end else begin
      foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
    end
    words_sent++;
  endtask

  // Sender holds off until every owed result word has come out, then lets
  // the flush cycle pass.
  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: results cannot be held off, so every strobe is a word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    stat_word_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word: sorted_value %0d rank %0d",
               out_sorted_value, out_rank);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("sorted_value", want.sorted_value, out_sorted_value);
        check_field("rank",         8'(want.rank),     8'(out_rank));
        check_field("end_of_run",   8'(want.end_of_run), 8'(out_end_of_run));
        check_field("mean_floor",   want.mean_floor,   out_mean_floor);
        check_field("median_floor", want.median_floor, out_median_floor);
        check_field("largest",      want.largest,      out_largest);
        check_field("smallest",     want.smallest,     out_smallest);
        check_field("set_size",     8'(want.set_size), 8'(out_set_size));
        check_field("overflowed",   8'(want.overflowed), 8'(out_overflowed));
      end
      results_seen++;
    end
  end

  // Watchdog: cycles with no word moving in either direction.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results owed",
                 quiet_cycles, pending_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  sample_row_t directed_rows [$];

  // typed = 1 only on a one-sample set: every value field is the sample itself
  function automatic void add_row(input logic [7:0] value, input logic last,
                                  input logic typed);
    sample_row_t r;
    r.value             = value;
    r.last              = last;
    r.typed             = typed;
    r.want.sorted_value = value;
    r.want.rank         = 6'd0;
    r.want.end_of_run   = 1'b1;
    r.want.mean_floor   = value;
    r.want.median_floor = value;
    r.want.largest      = value;
    r.want.smallest     = value;
    r.want.set_size     = 7'd1;
    r.want.overflowed   = 1'b0;
    directed_rows.push_back(r);
  endfunction

  initial begin : stimulus
    stat_word_t  no_want;
    int          rnd_words;
    int          set_idx;
    int          set_len;
    int          pick;
    logic [7:0]  value;
    logic [7:0]  prev_value;

    no_want    = '0;
    rnd_words  = 0;
    set_idx    = 0;
    prev_value = 8'h00;

    // first word right after reset, then the byte extremes alone
    add_row(8'h5A, 1'b1, 1'b1);
    add_row(8'h00, 1'b1, 1'b1);
    add_row(8'hFF, 1'b1, 1'b1);
    // extremes together: mean and median both floor(255/2)
    add_row(8'hFF, 1'b0, 1'b0);
    add_row(8'h00, 1'b1, 1'b0);
    // odd count, median is the middle rank
    add_row(8'd7,   1'b0, 1'b0);
    add_row(8'd3,   1'b0, 1'b0);
    add_row(8'd200, 1'b1, 1'b0);
    // ascending arrival: longest insertion walk
    add_row(8'd1, 1'b0, 1'b0);
    add_row(8'd2, 1'b0, 1'b0);
    add_row(8'd3, 1'b0, 1'b0);
    add_row(8'd4, 1'b1, 1'b0);
    // all equal
    add_row(8'd9, 1'b0, 1'b0);
    add_row(8'd9, 1'b0, 1'b0);
    add_row(8'd9, 1'b0, 1'b0);
    add_row(8'd9, 1'b1, 1'b0);
    // descending arrival: no walk at all
    add_row(8'd200, 1'b0, 1'b0);
    add_row(8'd100, 1'b0, 1'b0);
    add_row(8'd50,  1'b0, 1'b0);
    add_row(8'd25,  1'b1, 1'b0);
    // duplicate top values, even median from the two middles
    add_row(8'hFF, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0);
    add_row(8'hFE, 1'b0, 1'b0);
    add_row(8'h80, 1'b1, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].value, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].want);
    end

    // sender pause: block drains fully before the random part
    wait_all_results();

    // Random sets. The first one overfills the store by two words with the
    // last mark on a dropped word; later ones are mostly short, now and then
    // sized around capacity, trimmed to the words left. Words 90..129 go out
    // with no sender gaps.
    while (rnd_words < RANDOM_WORDS) begin
      if (set_idx == 0) begin
        set_len = MAX_SAMPLES + 2;
      end else if ($urandom_range(19) == 0) begin
        set_len = $urandom_range(MAX_SAMPLES + 3, MAX_SAMPLES - 1);
      end else begin
        set_len = $urandom_range(8, 1);
      end
      if (set_idx != 0 && set_len > RANDOM_WORDS - rnd_words) begin
        set_len = RANDOM_WORDS - rnd_words;
      end
      for (int k = 0; k < set_len; k++) begin
        idle_enabled = !(rnd_words >= 90 && rnd_words < 130);
        pick = $urandom_range(9);
        if (pick == 0) begin
          value = 8'h00;
        end else if (pick == 1) begin
          value = 8'hFF;
        end else if (pick == 2 && k > 0) begin
          value = prev_value;  // duplicates exercise the compare-equal path
        end else begin
          value = 8'($urandom_range(255));
        end
        prev_value = value;
        send_word(value, (k == set_len - 1), 1'b0, no_want);
        rnd_words++;
      end
      set_idx++;
      if ($urandom_range(7) == 0) wait_all_results();
    end

    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d sample words in %0d sets (%0d with dropped words)",
             words_sent, sets_closed, overflow_sets);
    $display("checked %0d result words, %0d mismatches", results_seen, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
